/* src/hmp_track_to_midi_transcoder_core_defines.svh */
// assertion helpers used by the transcoder emit stage
`ifndef HMP_TRACK_TO_MIDI_TRANSCODER_CORE_DEFINES_SVH
`define HMP_TRACK_TO_MIDI_TRANSCODER_CORE_DEFINES_SVH

// checked only while out of reset
`define HMP_T2M_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define HMP_T2M_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/hmp_t2m_pkg.sv */
`default_nettype none

package hmp_t2m_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        run_last;
    logic        done_res;
    logic [2:0]  status;
    logic [23:0] byte_count;
  } out_item_t;

  localparam int ByteCountW = 24;

  // end codes
  localparam logic [2:0] ST_RUNNING    = 3'd0;
  localparam logic [2:0] ST_END_META   = 3'd1;
  localparam logic [2:0] ST_DATA_ENDED = 3'd2;
  localparam logic [2:0] ST_BAD_DELTA  = 3'd3;
  localparam logic [2:0] ST_BAD_STATUS = 3'd4;
  localparam logic [2:0] ST_TRUNCATED  = 3'd5;

  localparam logic [7:0] META_LEAD    = 8'hFF;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [3:0] NIB_SYSTEM   = 4'hF;
  localparam logic [3:0] NIB_PROGRAM  = 4'hC;
  localparam logic [3:0] NIB_PRESSURE = 4'hD;

  // side info for one burst of results caused by one input byte
  typedef struct packed {
    logic       load;
    logic       has_byte;
    logic [2:0] status;
  } burst_ctl_t;

endpackage

`default_nettype wire

/* src/hmp_t2m_parse.sv */
`default_nettype none

module hmp_t2m_parse #(
  parameter int MAX_DELTA_BYTES = 4
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  accept_i,
  input  wire hmp_t2m_pkg::in_item_t                 in_i,
  output hmp_t2m_pkg::burst_ctl_t                    bst_ctl_o,
  output logic [$clog2(MAX_DELTA_BYTES+1)-1:0]       bst_cnt_o,
  output logic [MAX_DELTA_BYTES-1:0][7:0]            bst_bytes_o
);
  import hmp_t2m_pkg::*;

  localparam int FillW = $clog2(MAX_DELTA_BYTES);
  localparam int CntW  = $clog2(MAX_DELTA_BYTES + 1);
  localparam int GrpN  = MAX_DELTA_BYTES - 1;

  localparam logic [2:0] PH_DELTA     = 3'd0;
  localparam logic [2:0] PH_STATUS    = 3'd1;
  localparam logic [2:0] PH_CHDATA    = 3'd2;
  localparam logic [2:0] PH_META_TYPE = 3'd3;
  localparam logic [2:0] PH_META_LEN  = 3'd4;
  localparam logic [2:0] PH_META_DATA = 3'd5;
  localparam logic [2:0] PH_DONE      = 3'd6;

  logic [2:0]            phase_q, phase_d;
  logic [GrpN-1:0][6:0]  groups_q, groups_d;  // newest group at index 0
  logic [FillW-1:0]      fill_q, fill_d;
  logic [7:0]            prev_q, prev_d;
  logic [7:0]            remain_q, remain_d;
  logic                  is_end_q, is_end_d;
  logic [2:0]            end_code_q, end_code_d;

  logic [CntW-1:0]       n_bytes;
  logic [2:0]            fin;
  logic                  complete;
  logic                  meta_done;
  logic [7:0]            remain_dec;
  logic [7:0]            b;

  always_comb begin
    b           = in_i.in_byte;
    phase_d     = phase_q;
    groups_d    = groups_q;
    fill_d      = fill_q;
    prev_d      = prev_q;
    remain_d    = remain_q;
    is_end_d    = is_end_q;
    end_code_d  = end_code_q;
    n_bytes     = '0;
    bst_bytes_o = '0;
    fin         = ST_RUNNING;
    complete    = 1'b0;
    meta_done   = 1'b0;
    remain_dec  = (remain_q == 8'd0) ? 8'd0 : remain_q - 8'd1;

    unique case (phase_q)
      PH_DELTA: begin
        if (b[7]) begin
          // terminator first, then buffered groups newest to oldest
          bst_bytes_o[0] = {fill_q != '0, b[6:0]};
          for (int k = 1; k < MAX_DELTA_BYTES; k++) begin
            bst_bytes_o[k] = {(FillW'(k) < fill_q), groups_q[k-1]};
          end
          n_bytes = CntW'(fill_q) + CntW'(1);
          fill_d  = '0;
          phase_d = PH_STATUS;
        end else if (fill_q >= FillW'(MAX_DELTA_BYTES - 1)) begin
          fin = ST_BAD_DELTA;
        end else begin
          groups_d[0] = b[6:0];
          for (int j = 1; j < GrpN; j++) begin
            groups_d[j] = groups_q[j-1];
          end
          fill_d = fill_q + FillW'(1);
        end
      end
      PH_STATUS: begin
        if (b == META_LEAD) begin
          bst_bytes_o[0] = b;
          n_bytes        = CntW'(1);
          phase_d        = PH_META_TYPE;
        end else if (!b[7] || b[7:4] == NIB_SYSTEM) begin
          fin = ST_BAD_STATUS;
        end else begin
          // running status drops a repeated channel status
          if (b != prev_q) begin
            bst_bytes_o[0] = b;
            n_bytes        = CntW'(1);
          end
          prev_d   = b;
          remain_d = (b[7:4] == NIB_PROGRAM || b[7:4] == NIB_PRESSURE) ? 8'd1 : 8'd2;
          phase_d  = PH_CHDATA;
        end
      end
      PH_CHDATA: begin
        bst_bytes_o[0] = b;
        n_bytes        = CntW'(1);
        remain_d       = remain_dec;
        if (remain_dec == 8'd0) begin
          phase_d  = PH_DELTA;
          complete = 1'b1;
        end
      end
      PH_META_TYPE: begin
        bst_bytes_o[0] = b;
        n_bytes        = CntW'(1);
        is_end_d       = (b == META_EOT);
        phase_d        = PH_META_LEN;
      end
      PH_META_LEN: begin
        bst_bytes_o[0] = b;
        n_bytes        = CntW'(1);
        remain_d       = b;
        if (b == 8'd0) begin
          meta_done = 1'b1;
        end else begin
          phase_d = PH_META_DATA;
        end
      end
      PH_META_DATA: begin
        bst_bytes_o[0] = b;
        n_bytes        = CntW'(1);
        remain_d       = remain_dec;
        if (remain_dec == 8'd0) begin
          meta_done = 1'b1;
        end
      end
      PH_DONE: begin
        fin = end_code_q;
      end
      default: begin
        fin = end_code_q;
      end
    endcase

    if (phase_q != PH_DONE) begin
      if (meta_done) begin
        if (is_end_q) begin
          fin = ST_END_META;
        end else begin
          phase_d  = PH_DELTA;
          complete = 1'b1;
        end
      end
      if (fin == ST_RUNNING && in_i.in_last) begin
        fin = complete ? ST_DATA_ENDED : ST_TRUNCATED;
      end
      if (fin != ST_RUNNING) begin
        phase_d    = PH_DONE;
        end_code_d = fin;
      end
    end

    bst_ctl_o.has_byte = (n_bytes != '0);
    bst_ctl_o.status   = fin;
    bst_ctl_o.load     = accept_i && ((n_bytes != '0) || (fin != ST_RUNNING));
    bst_cnt_o          = (n_bytes == '0) ? CntW'(1) : n_bytes;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_DELTA;
      groups_q   <= '0;
      fill_q     <= '0;
      prev_q     <= '0;
      remain_q   <= '0;
      is_end_q   <= 1'b0;
      end_code_q <= ST_RUNNING;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      groups_q   <= groups_d;
      fill_q     <= fill_d;
      prev_q     <= prev_d;
      remain_q   <= remain_d;
      is_end_q   <= is_end_d;
      end_code_q <= end_code_d;
    end
  end

endmodule

`default_nettype wire

/* src/hmp_t2m_emit.sv */
`default_nettype none

module hmp_t2m_emit #(
  parameter int MAX_DELTA_BYTES = 4,
  parameter int COUNT_BITS      = 24
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire hmp_t2m_pkg::burst_ctl_t               bst_ctl_i,
  input  wire logic [$clog2(MAX_DELTA_BYTES+1)-1:0]  bst_cnt_i,
  input  wire logic [MAX_DELTA_BYTES-1:0][7:0]       bst_bytes_i,
  output logic                                       rdy_o,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output hmp_t2m_pkg::out_item_t                     out_o
);
  import hmp_t2m_pkg::*;
`include "hmp_track_to_midi_transcoder_core_defines.svh"

  localparam int CntW  = $clog2(MAX_DELTA_BYTES + 1);
  localparam int WideW = (COUNT_BITS > ByteCountW) ? COUNT_BITS : ByteCountW;

  logic                             bst_vld_q;
  logic [CntW-1:0]                  bst_cnt_q;
  burst_ctl_t                       bst_ctl_q;
  logic [MAX_DELTA_BYTES-1:0][7:0]  bytes_q, bytes_shift;
  logic [COUNT_BITS-1:0]            cnt_q, cnt_d, cnt_inc;
  logic [WideW-1:0]                 cnt_wide;
  logic                             out_vld_q;
  out_item_t                        out_q, out_d;
  logic                             out_load, pop, pop_last, run_last;

  always_comb begin
    out_load = !out_vld_q || !out_stall_i;
    pop      = bst_vld_q && out_load;
    run_last = (bst_cnt_q == CntW'(1));
    pop_last = pop && run_last;
    rdy_o    = !bst_vld_q || pop_last;

    for (int j = 0; j < MAX_DELTA_BYTES - 1; j++) begin
      bytes_shift[j] = bytes_q[j+1];
    end
    bytes_shift[MAX_DELTA_BYTES-1] = '0;

    // saturating running total of emitted bytes
    cnt_inc  = (&cnt_q) ? cnt_q : cnt_q + COUNT_BITS'(1);
    cnt_d    = (pop && bst_ctl_q.has_byte) ? cnt_inc : cnt_q;
    cnt_wide = WideW'(cnt_d);

    out_d.out_byte   = bst_ctl_q.has_byte ? bytes_q[0] : 8'd0;
    out_d.has_byte   = bst_ctl_q.has_byte;
    out_d.run_last   = run_last;
    out_d.done_res   = run_last && (bst_ctl_q.status != ST_RUNNING);
    out_d.status     = run_last ? bst_ctl_q.status : ST_RUNNING;
    out_d.byte_count = cnt_wide[ByteCountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bst_vld_q <= 1'b0;
      bst_cnt_q <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (bst_ctl_i.load) begin
        bst_vld_q <= 1'b1;
        bst_cnt_q <= bst_cnt_i;
      end else if (pop) begin
        bst_vld_q <= !run_last;
        bst_cnt_q <= bst_cnt_q - CntW'(1);
      end
      cnt_q <= cnt_d;
      if (out_load) begin
        out_vld_q <= pop;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bst_ctl_i.load) begin
      bytes_q   <= bst_bytes_i;
      bst_ctl_q <= bst_ctl_i;
    end else if (pop) begin
      bytes_q <= bytes_shift;
    end
    if (pop) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  `HMP_T2M_ASSERT(a_no_load_over_burst, bst_vld_q && !run_last |-> !bst_ctl_i.load, "burst overwritten before drained")
  `HMP_T2M_ASSERT(a_burst_nonempty, bst_vld_q |-> bst_cnt_q != '0, "pending burst with no results")
  `HMP_T2M_ASSERT(a_count_steps, pop && bst_ctl_q.has_byte |=> (cnt_q != $past(cnt_q)) || (&cnt_q), "byte count missed an emitted byte")
  `HMP_T2M_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_vld_q && !bst_vld_q, "activity during reset")

endmodule

`default_nettype wire

/* src/hmp_track_to_midi_transcoder_core.sv */
// Converts an HMP track, one byte per transfer on the input channel, into the
// bytes of a Standard MIDI track on the output channel. Each input byte is decoded
// in the cycle it is accepted and its results (zero to MAX_DELTA_BYTES of them)
// are placed in a burst register, which drains one result per cycle into the
// output register while the output is not stalled. One input byte can be
// accepted every cycle unless the output stalls; a byte that closes an
// n-group delta yields n results and holds the input while the burst
// register drains. Bytes that only fill the delta buffer or repeat a running
// status produce no result unless last. Once an end status is reported every
// later byte returns a single status-only result carrying the final code.
`default_nettype none

module hmp_track_to_midi_transcoder_core #(
  parameter int MAX_DELTA_BYTES = 4,
  parameter int COUNT_BITS      = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire hmp_t2m_pkg::in_item_t   in_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output hmp_t2m_pkg::out_item_t       out_o
);
  import hmp_t2m_pkg::*;

  localparam int CntW = $clog2(MAX_DELTA_BYTES + 1);

  logic                             rdy;
  logic                             accept;
  burst_ctl_t                       bst_ctl;
  logic [CntW-1:0]                  bst_cnt;
  logic [MAX_DELTA_BYTES-1:0][7:0]  bst_bytes;

  assign in_stall_o = !rdy;
  assign accept     = in_valid_i && rdy;

  hmp_t2m_parse #(
    .MAX_DELTA_BYTES(MAX_DELTA_BYTES)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_i),
    .bst_ctl_o  (bst_ctl),
    .bst_cnt_o  (bst_cnt),
    .bst_bytes_o(bst_bytes)
  );

  hmp_t2m_emit #(
    .MAX_DELTA_BYTES(MAX_DELTA_BYTES),
    .COUNT_BITS     (COUNT_BITS)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bst_ctl_i  (bst_ctl),
    .bst_cnt_i  (bst_cnt),
    .bst_bytes_i(bst_bytes),
    .rdy_o      (rdy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire
